@@ sv/fmtc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmtc_pkg
// Shared constants and types of the file head type classifier: window size,
// head snapshot layout and the type code list.
// ----------------------------------------------------------------------------
package fmtc_pkg;

  // bytes of the file head kept for matching
  localparam int unsigned WINDOW_BYTES = 12;
  // byte count holds 0..WINDOW_BYTES
  localparam int unsigned CNT_W        = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned CODE_W       = 5;

  // one captured file head, handed from front to back
  typedef struct packed {
    logic [WINDOW_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]             count;
  } head_snap_t;

  // result type codes
  typedef enum logic [CODE_W-1:0] {
    FT_OCTET     = 5'd0,
    FT_JPEG      = 5'd1,
    FT_PNG       = 5'd2,
    FT_GIF       = 5'd3,
    FT_BMP       = 5'd4,
    FT_WEBP      = 5'd5,
    FT_TIFF      = 5'd6,
    FT_HEIC      = 5'd7,
    FT_HEIF      = 5'd8,
    FT_AVIF      = 5'd9,
    FT_QUICKTIME = 5'd10,
    FT_MP4       = 5'd11,
    FT_WEBM      = 5'd12,
    FT_AVI       = 5'd13,
    FT_WAV       = 5'd14,
    FT_FLAC      = 5'd15,
    FT_OGG       = 5'd16,
    FT_MPEG      = 5'd17,
    FT_PDF       = 5'd18,
    FT_ZIP       = 5'd19,
    FT_GZIP      = 5'd20,
    FT_7Z        = 5'd21,
    FT_RAR       = 5'd22
  } ftype_t;

endpackage

@@ sv/fmtc_if.sv @@
// ----------------------------------------------------------------------------
// fmtc_in_if / fmtc_out_if
// Valid/ready channels of the classifier: one file head byte per word in,
// one type code per word out.
// ----------------------------------------------------------------------------
interface fmtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;

  modport source (output valid, output data_byte, output byte_present,
                  output last_item, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input last_item, output ready);
endinterface

interface fmtc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] type_code;

  modport source (output valid, output type_code, input ready);
  modport sink   (input valid, input type_code, output ready);
endinterface

@@ sv/file_magic_type_classifier.sv @@
// ----------------------------------------------------------------------------
// file_magic_type_classifier
// Identifies a file type from the magic signature at the head of the file.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per cycle: data_byte, byte_present and last_item.
//   Words without byte_present only advance toward last_item. The first
//   twelve present bytes are kept; later ones are dropped.
//   A word with last_item closes the head and yields exactly one type_code
//   word on out_ch; the head is then cleared for the next file.
//   Throughput: one input word per cycle while in_ch.ready is high, including back-to-back heads.
//   The closed head enters a two-entry queue when the last_item word is
//   taken; signature matching loads its type_code into the output register
//   once that register is empty or being taken.
//   Stall: when out_ch is held off, the output register and the queue fill
//   up; in_ch.ready drops only while the queue holds two closed heads.
//   Reset (rst_n low, synchronous) empties the queue and output register
//   and clears the byte count.
// ----------------------------------------------------------------------------
module file_magic_type_classifier
  import fmtc_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  fmtc_in_if.sink     in_ch,
  fmtc_out_if.source  out_ch
);

  logic       push, q_full, pop, q_valid;
  head_snap_t push_snap, q_snap;

  fmtc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data_byte    (in_ch.data_byte),
    .in_byte_present (in_ch.byte_present),
    .in_last_item    (in_ch.last_item),
    .q_full          (q_full),
    .push            (push),
    .push_snap       (push_snap)
  );

  fmtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_snap (push_snap),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_snap    (q_snap)
  );

  fmtc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_snap        (q_snap),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_type_code (out_ch.type_code)
  );

endmodule

@@ sv/fmtc_front.sv @@
// ----------------------------------------------------------------------------
// fmtc_front
// Capture side: stores the first WINDOW_BYTES bytes of the head and a
// saturating count; on the last word pushes the finished head to the queue.
// ----------------------------------------------------------------------------
module fmtc_front
  import fmtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_last_item,
  input  logic       q_full,
  output logic       push,
  output head_snap_t push_snap
);

  logic [WINDOW_BYTES-1:0][7:0] head_r, head_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         take, store;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign store    = take && in_byte_present && (count_r < CNT_W'(WINDOW_BYTES));

  // lane write: the byte lands at the current count
  always_comb begin
    head_nxt = head_r;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (store && (count_r == CNT_W'(i))) begin
        head_nxt[i] = in_data_byte;
      end
    end
    count_nxt = store ? count_r + CNT_W'(1) : count_r;
  end

  // finished head includes a byte carried on the last word
  assign push            = take && in_last_item;
  assign push_snap.bytes = head_nxt;
  assign push_snap.count = count_nxt;

  // window bytes past the count are never looked at, so they need no reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ sv/fmtc_queue.sv @@
// ----------------------------------------------------------------------------
// fmtc_queue
// Two-entry queue of finished heads between capture and classification.
// ----------------------------------------------------------------------------
module fmtc_queue
  import fmtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  head_snap_t push_snap,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output head_snap_t q_snap
);

  head_snap_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign full    = (fill_r == 2'd2);
  assign q_valid = (fill_r != 2'd0);
  assign q_snap  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_snap;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

@@ sv/fmtc_back.sv @@
// ----------------------------------------------------------------------------
// fmtc_back
// Classification side: matches a queued head against the signature priority
// list and holds the type code in the output register.
// ----------------------------------------------------------------------------
module fmtc_back
  import fmtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  head_snap_t        q_snap,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_type_code
);

  logic [WINDOW_BYTES-1:0][7:0] h;
  logic [CNT_W-1:0]             cnt;
  logic                         n2, n3, n4, n5, n6, n8, n12;
  logic                         riff, ftyp, tag_webp, tag_avi, tag_wave;
  logic                         b_heic, b_heif, b_avif, b_qt;
  ftype_t                       code_nxt;
  logic                         out_valid_r;
  logic [CODE_W-1:0]            code_r;

  assign h   = q_snap.bytes;
  assign cnt = q_snap.count;

  // byte presence thresholds
  assign n2  = cnt >= CNT_W'(2);
  assign n3  = cnt >= CNT_W'(3);
  assign n4  = cnt >= CNT_W'(4);
  assign n5  = cnt >= CNT_W'(5);
  assign n6  = cnt >= CNT_W'(6);
  assign n8  = cnt >= CNT_W'(8);
  assign n12 = cnt >= CNT_W'(12);

  // shared pieces: RIFF header, ftyp box, four-byte tag at offset 8
  assign riff     = n4 && h[0] == "R" && h[1] == "I" && h[2] == "F" && h[3] == "F";
  assign ftyp     = n8 && h[4] == "f" && h[5] == "t" && h[6] == "y" && h[7] == "p";
  assign tag_webp = n12 && h[8] == "W" && h[9] == "E" && h[10] == "B" && h[11] == "P";
  assign tag_avi  = n12 && h[8] == "A" && h[9] == "V" && h[10] == "I" && h[11] == " ";
  assign tag_wave = n12 && h[8] == "W" && h[9] == "A" && h[10] == "V" && h[11] == "E";

  // ISO media brands
  assign b_heic = n12 && h[8] == "h" && h[9] == "e" &&
                  ((h[10] == "i" && h[11] == "c") || (h[10] == "i" && h[11] == "x") ||
                   (h[10] == "v" && h[11] == "c") || (h[10] == "i" && h[11] == "m"));
  assign b_heif = n12 && h[8] == "m" && (h[9] == "i" || h[9] == "s") &&
                  h[10] == "f" && h[11] == "1";
  assign b_avif = n12 && h[8] == "a" && h[9] == "v" && h[10] == "i" &&
                  (h[11] == "f" || h[11] == "s");
  assign b_qt   = n12 && h[8] == "q" && h[9] == "t" && h[10] == " " && h[11] == " ";

  // signature priority list
  always_comb begin
    code_nxt = FT_OCTET;
    if (n3 && h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
      code_nxt = FT_JPEG;
    end else if (n8 && h[0] == 8'h89 && h[1] == "P" && h[2] == "N" && h[3] == "G" &&
                 h[4] == 8'h0D && h[5] == 8'h0A && h[6] == 8'h1A && h[7] == 8'h0A) begin
      code_nxt = FT_PNG;
    end else if (n6 && h[0] == "G" && h[1] == "I" && h[2] == "F" && h[3] == "8" &&
                 (h[4] == "7" || h[4] == "9") && h[5] == "a") begin
      code_nxt = FT_GIF;
    end else if (n2 && h[0] == "B" && h[1] == "M") begin
      code_nxt = FT_BMP;
    end else if (riff && tag_webp) begin
      code_nxt = FT_WEBP;
    end else if (n4 && ((h[0] == "I" && h[1] == "I" && h[2] == "*" && h[3] == 8'h00) ||
                        (h[0] == "M" && h[1] == "M" && h[2] == 8'h00 && h[3] == "*"))) begin
      code_nxt = FT_TIFF;
    end else if (ftyp) begin
      if (b_heic) begin
        code_nxt = FT_HEIC;
      end else if (b_heif) begin
        code_nxt = FT_HEIF;
      end else if (b_avif) begin
        code_nxt = FT_AVIF;
      end else if (b_qt) begin
        code_nxt = FT_QUICKTIME;
      end else begin
        code_nxt = FT_MP4;
      end
    end else if (n4 && h[0] == 8'h1A && h[1] == 8'h45 && h[2] == 8'hDF && h[3] == 8'hA3) begin
      code_nxt = FT_WEBM;
    end else if (riff && tag_avi) begin
      code_nxt = FT_AVI;
    end else if (riff && tag_wave) begin
      code_nxt = FT_WAV;
    end else if (n4 && h[0] == "f" && h[1] == "L" && h[2] == "a" && h[3] == "C") begin
      code_nxt = FT_FLAC;
    end else if (n4 && h[0] == "O" && h[1] == "g" && h[2] == "g" && h[3] == "S") begin
      code_nxt = FT_OGG;
    end else if ((n3 && h[0] == "I" && h[1] == "D" && h[2] == "3") ||
                 (n2 && h[0] == 8'hFF && h[1] == 8'hFB)) begin
      code_nxt = FT_MPEG;
    end else if (n5 && h[0] == "%" && h[1] == "P" && h[2] == "D" && h[3] == "F" &&
                 h[4] == "-") begin
      code_nxt = FT_PDF;
    end else if (n4 && h[0] == "P" && h[1] == "K" && h[2] == 8'h03 && h[3] == 8'h04) begin
      code_nxt = FT_ZIP;
    end else if (n2 && h[0] == 8'h1F && h[1] == 8'h8B) begin
      code_nxt = FT_GZIP;
    end else if (n6 && h[0] == "7" && h[1] == "z" && h[2] == 8'hBC && h[3] == 8'hAF &&
                 h[4] == 8'h27 && h[5] == 8'h1C) begin
      code_nxt = FT_7Z;
    end else if (n6 && h[0] == "R" && h[1] == "a" && h[2] == "r" && h[3] == "!" &&
                 h[4] == 8'h1A && h[5] == 8'h07) begin
      code_nxt = FT_RAR;
    end
  end

  // output register: reload whenever empty or being taken
  assign pop = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r <= code_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_type_code = code_r;

endmodule

@@ dv/file_magic_type_classifier_test.sv @@
// ----------------------------------------------------------------------------
// file_magic_type_classifier_test
// Self-checking bench for the file head type classifier. File heads are built
// from magic signatures with random tails, truncation and corrupted bytes,
// plus plain noise. They are streamed one byte word at a time with random
// bursts and gaps. A local copy of the head window predicts the type code of
// every closed head, and each out_ch word is checked in order.
// ----------------------------------------------------------------------------
module file_magic_type_classifier_test;
  import fmtc_pkg::*;

  localparam int          MAGIC_KINDS  = 22;
  localparam int          BRAND_KINDS  = 12;
  localparam int          LIVE_TARGET  = 1200;
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // one input word plus a bench-only flag that holds it until results drain
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       last;
    bit         pause;
  } stim_word_t;

  logic clk = 1'b0;
  logic rst_n;

  fmtc_in_if  in_ch ();
  fmtc_out_if out_ch ();

  file_magic_type_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  stim_word_t  pending[$];
  logic [7:0]  head_buf[$];
  ftype_t      type_q[$];
  int          live_words;
  bit          pause_next;
  int          fails;
  int unsigned cycle_cnt;

  // predicted head window
  logic [7:0]  head_mem [WINDOW_BYTES];
  int unsigned head_cnt;

  // ---------------------------------------------------------------- predictor

  // n bytes of pat (first byte leftmost) sit at off and are all present
  function automatic bit head_has(int unsigned off, logic [63:0] pat, int unsigned n);
    if (head_cnt < off + n || off + n > WINDOW_BYTES) return 1'b0;
    for (int i = 0; i < n; i++)
      if (head_mem[off+i] != pat[8*(n-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit brand_is(logic [31:0] b);
    return head_has(8, b, 4);
  endfunction

  function automatic ftype_t classify_head();
    if (head_cnt == 0) return FT_OCTET;
    if (head_has(0, 64'hFFD8FF, 3)) return FT_JPEG;
    if (head_has(0, {8'h89, "PNG", 8'h0D, 8'h0A, 8'h1A, 8'h0A}, 8)) return FT_PNG;
    if (head_has(0, "GIF87a", 6) || head_has(0, "GIF89a", 6)) return FT_GIF;
    if (head_has(0, "BM", 2)) return FT_BMP;
    if (head_has(0, "RIFF", 4) && head_has(8, "WEBP", 4)) return FT_WEBP;
    if (head_has(0, {"II*", 8'h00}, 4) || head_has(0, {"MM", 8'h00, "*"}, 4))
      return FT_TIFF;
    if (head_has(4, "ftyp", 4)) begin
      if (brand_is("heic") || brand_is("heix") || brand_is("hevc") || brand_is("heim"))
        return FT_HEIC;
      if (brand_is("mif1") || brand_is("msf1")) return FT_HEIF;
      if (brand_is("avif") || brand_is("avis")) return FT_AVIF;
      if (brand_is("qt  ")) return FT_QUICKTIME;
      return FT_MP4;
    end
    if (head_has(0, 64'h1A45DFA3, 4)) return FT_WEBM;
    if (head_has(0, "RIFF", 4) && head_has(8, "AVI ", 4)) return FT_AVI;
    if (head_has(0, "RIFF", 4) && head_has(8, "WAVE", 4)) return FT_WAV;
    if (head_has(0, "fLaC", 4)) return FT_FLAC;
    if (head_has(0, "OggS", 4)) return FT_OGG;
    if (head_has(0, "ID3", 3) || head_has(0, 64'hFFFB, 2)) return FT_MPEG;
    if (head_has(0, "%PDF-", 5)) return FT_PDF;
    if (head_has(0, {"PK", 8'h03, 8'h04}, 4)) return FT_ZIP;
    if (head_has(0, 64'h1F8B, 2)) return FT_GZIP;
    if (head_has(0, {"7z", 8'hBC, 8'hAF, 8'h27, 8'h1C}, 6)) return FT_7Z;
    if (head_has(0, {"Rar!", 8'h1A, 8'h07}, 6)) return FT_RAR;
    return FT_OCTET;
  endfunction

  // fold one accepted word into the window; a closing word yields a code
  function automatic void absorb_word(logic [7:0] d, logic present, logic last);
    if (present && head_cnt < WINDOW_BYTES) begin
      head_mem[head_cnt] = d;
      head_cnt++;
    end
    if (last) begin
      type_q.push_back(classify_head());
      head_cnt = 0;
      foreach (head_mem[i]) head_mem[i] = '0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_bytes(input logic [95:0] s, input int n);
    for (int i = 0; i < n; i++) head_buf.push_back(s[8*(n-1-i) +: 8]);
  endtask

  task automatic add_rand(input int n);
    for (int i = 0; i < n; i++) head_buf.push_back(8'($urandom));
  endtask

  function automatic logic [31:0] iso_brand(int k);
    case (k)
      0:       return "heic";
      1:       return "heix";
      2:       return "hevc";
      3:       return "heim";
      4:       return "mif1";
      5:       return "msf1";
      6:       return "avif";
      7:       return "avis";
      8:       return "qt  ";
      9:       return "mp42";
      default: return $urandom;
    endcase
  endfunction

  // append a signature of the given kind to head_buf; any other kind gives RIFF with a random tail
  task automatic build_magic(input int kind, input int brand_k);
    case (kind)
      0:  add_bytes(96'hFFD8FF, 3);
      1:  add_bytes({8'h89, "PNG", 8'h0D, 8'h0A, 8'h1A, 8'h0A}, 8);
      2:  add_bytes("GIF87a", 6);
      3:  add_bytes("GIF89a", 6);
      4:  add_bytes("BM", 2);
      5:  begin add_bytes("RIFF", 4); add_rand(4); add_bytes("WEBP", 4); end
      6:  add_bytes({"II*", 8'h00}, 4);
      7:  add_bytes({"MM", 8'h00, "*"}, 4);
      8:  begin add_rand(4); add_bytes("ftyp", 4); add_bytes(iso_brand(brand_k), 4); end
      9:  add_bytes(96'h1A45DFA3, 4);
      10: begin add_bytes("RIFF", 4); add_rand(4); add_bytes("AVI ", 4); end
      11: begin add_bytes("RIFF", 4); add_rand(4); add_bytes("WAVE", 4); end
      12: add_bytes("fLaC", 4);
      13: add_bytes("OggS", 4);
      14: add_bytes("ID3", 3);
      15: add_bytes(96'hFFFB, 2);
      16: add_bytes("%PDF-", 5);
      17: add_bytes({"PK", 8'h03, 8'h04}, 4);
      18: add_bytes(96'h1F8B, 2);
      19: add_bytes({"7z", 8'hBC, 8'hAF, 8'h27, 8'h1C}, 6);
      20: add_bytes({"Rar!", 8'h1A, 8'h07}, 6);
      default: begin add_bytes("RIFF", 4); add_rand(8); end
    endcase
  endtask

  task automatic push_word(input logic [7:0] d, input logic present, input logic last);
    stim_word_t w;
    w.data    = d;
    w.present = present;
    w.last    = last;
    w.pause   = pause_next;
    pause_next = 1'b0;
    pending.push_back(w);
    if (present || last) live_words++;
  endtask

  // turn head_buf into byte words, with optional empty words mixed in
  task automatic emit_head(input bit pause_first, input int filler_pct);
    bit last_on_byte;
    int n;
    n = head_buf.size();
    pause_next   = pause_first;
    last_on_byte = (n != 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < filler_pct) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(head_buf[i], 1'b1, last_on_byte && (i == n - 1));
    end
    if (!last_on_byte) push_word(8'($urandom), 1'b0, 1'b1);
    head_buf.delete();
  endtask

  task automatic trim_head(input int keep);
    while (head_buf.size() > keep) void'(head_buf.pop_back());
  endtask

  // ---------------------------------------------------------------- driver
  bit in_taken;
  int burst_left;
  int gap_left;

  // record and predict every accepted word
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_word(in_ch.data_byte, in_ch.byte_present, in_ch.last_item);
      in_taken = 1'b1;
    end
  end

  // present the next word in bursts; a paused word waits for all results
  always @(negedge clk) begin
    stim_word_t w;
    bit         drive;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      drive    = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending.size() != 0 && !(pending[0].pause && type_q.size() != 0)) begin
        w     = pending.pop_front();
        drive = 1'b1;
        in_ch.data_byte    <= w.data;
        in_ch.byte_present <= w.present;
        in_ch.last_item    <= w.last;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          burst_left--;
        end
      end
      in_ch.valid <= drive;
    end
  end

  // ---------------------------------------------------------------- receiver
  int  rdy_run;
  bit  rdy_state;

  // ready follows runs: long open stretches, long stalls, or quick toggling
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rdy_run == 0) begin
        case ($urandom_range(0, 3))
          0: begin rdy_state = 1'b1; rdy_run = $urandom_range(20, 60); end
          1: begin rdy_state = 1'b0; rdy_run = $urandom_range(1, 12); end
          default: begin
            rdy_state = $urandom_range(0, 1);
            rdy_run   = $urandom_range(1, 3);
          end
        endcase
      end
      rdy_run--;
      out_ch.ready <= rdy_state;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    ftype_t exp_code;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (type_q.size() == 0) begin
        $error("type_code: no result expected, actual %0d", out_ch.type_code);
        fails++;
      end else begin
        exp_code = type_q.pop_front();
        if (out_ch.type_code !== exp_code) begin
          $error("type_code: expected %0d (%s), actual %0d",
                 exp_code, exp_code.name(), out_ch.type_code);
          fails++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int r;
    int kind;
    int idx;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_item    = 1'b0;
    out_ch.ready       = 1'b0;
    fails      = 0;
    cycle_cnt  = 0;
    live_words = 0;
    pause_next = 1'b0;
    in_taken   = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    rdy_run    = 0;
    head_cnt   = 0;
    foreach (head_mem[i]) head_mem[i] = '0;

    // directed: empty head, closing word without a byte
    emit_head(1'b0, 0);
    emit_head(1'b0, 60);
    // every signature, bare
    for (int k = 0; k < MAGIC_KINDS; k++) begin
      build_magic(k, 9);
      emit_head(1'b0, 0);
    end
    // every ISO brand
    for (int k = 0; k < BRAND_KINDS - 1; k++) begin
      build_magic(8, k);
      emit_head(k == 0, 10);
    end
    // ftyp head too short for a brand gives mp4
    build_magic(8, 0);
    trim_head(8);
    emit_head(1'b0, 0);
    // png one byte short
    build_magic(1, 0);
    trim_head(7);
    emit_head(1'b0, 0);
    // bytes past the window are dropped
    build_magic(19, 0);
    add_rand(20);
    emit_head(1'b0, 20);
    add_bytes(96'h0, 12);
    emit_head(1'b0, 0);
    for (int k = 0; k < 14; k++) head_buf.push_back(8'hFF);
    emit_head(1'b0, 0);

    // random: mostly signatures with random tails, some broken, some noise
    while (live_words < LIVE_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        kind = $urandom_range(0, MAGIC_KINDS - 1);
        build_magic(kind, $urandom_range(0, BRAND_KINDS - 1));
        if ($urandom_range(0, 9) == 0) add_rand($urandom_range(0, 16));
        else add_rand($urandom_range(0, 6));
        if ($urandom_range(0, 9) == 0) trim_head($urandom_range(0, head_buf.size() - 1));
        if (head_buf.size() != 0 && $urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, head_buf.size() - 1);
          head_buf[idx] ^= 8'($urandom_range(1, 255));
        end
      end else begin
        add_rand($urandom_range(0, 20));
      end
      emit_head($urandom_range(0, 29) == 0, 15);
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_ch.valid) @(posedge clk);
    while (type_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
